@@ hw/rtl/itsp_pkg.sv @@
// Package for the ISO 8601 timestamp parser: parse phases, back-end states,
// the queued parse record, and the constant tables. No dependencies.
`default_nettype none
package itsp_pkg;

    typedef enum logic [3:0] {
        PH_YEAR       = 4'd0,
        PH_AFTER_YEAR = 4'd1,
        PH_MON        = 4'd2,
        PH_AFTER_MON  = 4'd3,
        PH_DAY        = 4'd4,
        PH_AFTER_DAY  = 4'd5,
        PH_HOUR       = 4'd6,
        PH_AFTER_HOUR = 4'd7,
        PH_MIN        = 4'd8,
        PH_AFTER_MIN  = 4'd9,
        PH_SEC        = 4'd10,
        PH_AFTER_SEC  = 4'd11,
        PH_FRAC       = 4'd12
    } phase_t;

    typedef enum logic [2:0] {
        BK_IDLE = 3'd0,
        BK_NORM = 3'd1,
        BK_DIV  = 3'd2,
        BK_DAYS = 3'd3,
        BK_SECS = 3'd4,
        BK_FIN  = 3'd5
    } back_state_t;

    // One finished parse, handed from the front end to the converter.
    typedef struct packed {
        logic              ok;
        logic [13:0]       year;
        logic signed [7:0] mon;     // zero-based month, -1 .. 98
        logic [6:0]        day;
        logic [6:0]        hour;
        logic [6:0]        minute;
        logic [6:0]        second;
        logic [29:0]       frac;
    } item_t;

    localparam logic [24:0] DAYS_TO_1970 = 25'd719162;
    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [7:0]  CH_NINE  = 8'h39;
    localparam logic [7:0]  CH_Z     = 8'h5A;
    localparam logic [7:0]  CH_T     = 8'h54;
    localparam logic [7:0]  CH_DASH  = 8'h2D;
    localparam logic [7:0]  CH_COLON = 8'h3A;
    localparam logic [7:0]  CH_DOT   = 8'h2E;
    localparam logic [7:0]  CH_SPACE = 8'h20;
    localparam logic [7:0]  CH_TAB   = 8'h09;
    localparam logic [7:0]  CH_CR    = 8'h0D;

    // Place value of the fraction digit at a given position.
    function automatic logic [26:0] frac_weight(input logic [3:0] pos);
        logic [26:0] w;
        begin
            case (pos)
                4'd0:    w = 27'd100000000;
                4'd1:    w = 27'd10000000;
                4'd2:    w = 27'd1000000;
                4'd3:    w = 27'd100000;
                4'd4:    w = 27'd10000;
                4'd5:    w = 27'd1000;
                4'd6:    w = 27'd100;
                4'd7:    w = 27'd10;
                4'd8:    w = 27'd1;
                default: w = 27'd0;
            endcase
            return w;
        end
    endfunction

    // Days before the first of a zero-based month.
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] mon);
        logic [8:0] d;
        begin
            case (mon)
                4'd0:    d = 9'd0;
                4'd1:    d = 9'd31;
                4'd2:    d = 9'd59;
                4'd3:    d = 9'd90;
                4'd4:    d = 9'd120;
                4'd5:    d = 9'd151;
                4'd6:    d = 9'd181;
                4'd7:    d = 9'd212;
                4'd8:    d = 9'd243;
                4'd9:    d = 9'd273;
                4'd10:   d = 9'd304;
                4'd11:   d = 9'd334;
                default: d = 9'd0;
            endcase
            if (leap && mon >= 4'd2 && mon <= 4'd11)
            begin
                d = d + 9'd1;
            end
            return d;
        end
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/itsp_front.sv @@
// Front end of the timestamp parser: takes one character per cycle while accept
// is high, and tracks the grammar. Depends on itsp_pkg.
`default_nettype none
module itsp_front
    import itsp_pkg::*;
#(
    parameter int FRACTION_DIGITS = 9
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] char_code,
    input  wire logic       end_of_string,
    input  wire logic       ws_ends,
    output logic            rec_push,
    output item_t           rec_data
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  minute_reg, minute_next;
    logic [6:0]  second_reg, second_next;
    logic [29:0] frac_reg, frac_next;
    logic        zone_reg, zone_next;
    logic        failed_reg, failed_next;
    logic        finished_reg, finished_next;

    logic        dig;
    logic [3:0]  d;
    logic        blank;
    logic [3:0]  cnt_inc;
    phase_t      phase_inc;
    logic [6:0]  two_digit;
    logic        has_mon;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_YEAR;
            cnt_reg      <= 4'd0;
            year_reg     <= 14'd0;
            month_reg    <= 7'd0;
            day_reg      <= 7'd1;
            hour_reg     <= 7'd0;
            minute_reg   <= 7'd0;
            second_reg   <= 7'd0;
            frac_reg     <= 30'd0;
            zone_reg     <= 1'b0;
            failed_reg   <= 1'b0;
            finished_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            year_reg     <= year_next;
            month_reg    <= month_next;
            day_reg      <= day_next;
            hour_reg     <= hour_next;
            minute_reg   <= minute_next;
            second_reg   <= second_next;
            frac_reg     <= frac_next;
            zone_reg     <= zone_next;
            failed_reg   <= failed_next;
            finished_reg <= finished_next;
        end
    end

    assign dig       = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign d         = dig ? 4'(char_code - CH_ZERO) : 4'd0;
    assign blank     = ws_ends && ((char_code == CH_SPACE) ||
                       ((char_code >= CH_TAB) && (char_code <= CH_CR)));
    assign cnt_inc   = cnt_reg + 4'd1;
    assign phase_inc = phase_t'(4'(phase_reg) + 4'd1);
    assign has_mon   = 4'(phase_reg) >= 4'(PH_AFTER_MON);

    // Record handed to the converter when the end item arrives.
    always_comb
    begin
        rec_data.ok     = !failed_reg && (finished_reg || zone_reg ||
                          phase_reg == PH_AFTER_YEAR || phase_reg == PH_AFTER_MON ||
                          phase_reg == PH_AFTER_DAY);
        rec_data.year   = year_reg;
        rec_data.mon    = has_mon ? $signed({1'b0, month_reg} - 8'd1) : 8'sd0;
        rec_data.day    = day_reg;
        rec_data.hour   = hour_reg;
        rec_data.minute = minute_reg;
        rec_data.second = second_reg;
        rec_data.frac   = frac_reg;
    end

    always_comb
    begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        year_next     = year_reg;
        month_next    = month_reg;
        day_next      = day_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;
        frac_next     = frac_reg;
        zone_next     = zone_reg;
        failed_next   = failed_reg;
        finished_next = finished_reg;
        rec_push      = 1'b0;
        two_digit     = 7'd0;

        if (accept && end_of_string)
        begin
            rec_push      = 1'b1;
            phase_next    = PH_YEAR;
            cnt_next      = 4'd0;
            year_next     = 14'd0;
            month_next    = 7'd0;
            day_next      = 7'd1;
            hour_next     = 7'd0;
            minute_next   = 7'd0;
            second_next   = 7'd0;
            frac_next     = 30'd0;
            zone_next     = 1'b0;
            failed_next   = 1'b0;
            finished_next = 1'b0;
        end
        else if (accept && !failed_reg && !finished_reg)
        begin
            if (zone_reg)
            begin
                if (blank)
                begin
                    finished_next = 1'b1;
                end
                else
                begin
                    failed_next = 1'b1;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_YEAR:
                    begin
                        if (!dig)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            year_next = 14'(year_reg * 14'd10) + {10'd0, d};
                            cnt_next  = cnt_inc;
                            if (cnt_inc == 4'd4)
                            begin
                                cnt_next   = 4'd0;
                                phase_next = phase_inc;
                                if (year_next < 14'd1970)
                                begin
                                    failed_next = 1'b1;
                                end
                            end
                        end
                    end
                    PH_MON, PH_DAY, PH_HOUR, PH_MIN, PH_SEC:
                    begin
                        if (!dig)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            case (phase_reg)
                                PH_MON:  two_digit = month_reg;
                                PH_DAY:  two_digit = (cnt_reg == 4'd0) ? 7'd0 : day_reg;
                                PH_HOUR: two_digit = hour_reg;
                                PH_MIN:  two_digit = minute_reg;
                                default: two_digit = second_reg;
                            endcase
                            two_digit = 7'(two_digit * 7'd10) + {3'd0, d};
                            case (phase_reg)
                                PH_MON:  month_next  = two_digit;
                                PH_DAY:  day_next    = two_digit;
                                PH_HOUR: hour_next   = two_digit;
                                PH_MIN:  minute_next = two_digit;
                                default: second_next = two_digit;
                            endcase
                            cnt_next = cnt_inc;
                            if (cnt_inc == 4'd2)
                            begin
                                cnt_next   = 4'd0;
                                phase_next = phase_inc;
                            end
                        end
                    end
                    PH_AFTER_YEAR, PH_AFTER_MON:
                    begin
                        if (blank)
                        begin
                            finished_next = 1'b1;
                        end
                        else if (char_code == CH_DASH)
                        begin
                            phase_next = phase_inc;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_AFTER_DAY:
                    begin
                        if (blank)
                        begin
                            finished_next = 1'b1;
                        end
                        else if (char_code == CH_T)
                        begin
                            phase_next = phase_inc;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_AFTER_HOUR, PH_AFTER_MIN:
                    begin
                        if (char_code == CH_Z)
                        begin
                            zone_next = 1'b1;
                        end
                        else if (char_code == CH_COLON)
                        begin
                            phase_next = phase_inc;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_AFTER_SEC:
                    begin
                        if (char_code == CH_Z)
                        begin
                            zone_next = 1'b1;
                        end
                        else if (char_code == CH_DOT)
                        begin
                            phase_next = PH_FRAC;
                            cnt_next   = 4'd0;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    PH_FRAC:
                    begin
                        if (dig && (cnt_reg < 4'(FRACTION_DIGITS)) && (cnt_reg < 4'd9))
                        begin
                            frac_next = frac_reg + 30'(d) * {3'd0, frac_weight(cnt_reg)};
                            cnt_next  = cnt_inc;
                        end
                        else if ((char_code == CH_Z) && (cnt_reg >= 4'd1))
                        begin
                            zone_next = 1'b1;
                        end
                        else
                        begin
                            failed_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        failed_next = 1'b1;
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/itsp_queue.sv @@
// Two-entry queue of parse records between the front end and the
// converter. Depends on itsp_pkg.
`default_nettype none
module itsp_queue
    import itsp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  item_t      wr_data,
    output logic       full,
    input  wire logic  rd_en,
    output logic       not_empty,
    output item_t      rd_data
);

    item_t      entries_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign rd_data   = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        count_next  = count_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/itsp_back.sv @@
// Converter: turns a parse record into epoch seconds through a chain of states
// and holds the result in an output register. Depends on itsp_pkg.
`default_nettype none
module itsp_back
    import itsp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     rec_avail,
    input  item_t         rec_data,
    output logic          rec_take,
    output logic          out_valid,
    input  wire logic     out_pop,
    output logic          time_valid,
    output logic [38:0]   epoch_seconds,
    output logic [29:0]   nanoseconds
);

    back_state_t state_reg, state_next;
    item_t       item_reg;
    logic [13:0] y_reg;
    logic [3:0]  midx_reg;
    logic [13:0] p_reg;
    logic [11:0] q4_reg;
    logic [7:0]  q25_reg;
    logic        leap_reg;
    logic [24:0] days_reg;
    logic [38:0] secs_reg;
    logic        out_valid_reg, out_valid_next;
    logic        time_valid_reg;
    logic [38:0] epoch_reg;
    logic [29:0] ns_reg;

    logic [12:0] mprod;
    logic [3:0]  mq;
    logic [13:0] y_norm;
    logic [3:0]  midx_norm;
    logic [13:0] p_w;
    logic [23:0] prod_p;
    logic [23:0] prod_y;
    logic [7:0]  cent;
    logic        leap_w;
    logic [24:0] days_w;
    logic signed [42:0] sprod;
    logic [38:0] secs_w;
    logic        ok_w;

    assign rec_take      = (state_reg == BK_IDLE) && rec_avail && !out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign time_valid    = time_valid_reg;
    assign epoch_seconds = epoch_reg;
    assign nanoseconds   = ns_reg;

    // Month overflow carries into the year; month minus one borrows a year.
    always_comb
    begin
        mprod     = {6'd0, item_reg.mon[6:0]} * 13'd43;
        mq        = mprod[12:9];
        y_norm    = item_reg.year;
        midx_norm = item_reg.mon[3:0];
        if (item_reg.mon > 8'sd11)
        begin
            y_norm    = item_reg.year + {10'd0, mq};
            midx_norm = 4'(item_reg.mon[6:0] - 7'(mq * 7'd12));
        end
        else if (item_reg.mon < 8'sd0)
        begin
            y_norm    = item_reg.year - 14'd1;
            midx_norm = 4'd11;
        end
    end

    // Divisions by 100 and 400 go through a reciprocal of 25 on value / 4.
    always_comb
    begin
        p_w    = y_reg - 14'd1;
        prod_p = p_w[13:2] * 12'd2622;
        prod_y = y_reg[13:2] * 12'd2622;
        cent   = prod_y[23:16];
        leap_w = (y_reg[1:0] == 2'd0) &&
                 ((y_reg != 14'(cent * 14'd100)) || (cent[1:0] == 2'd0));
    end

    always_comb
    begin
        days_w = 25'(p_reg) * 25'd365 + {19'd0, q25_reg[7:2]} - {17'd0, q25_reg}
               + {13'd0, q4_reg} - DAYS_TO_1970
               + {16'd0, month_start(leap_reg, midx_reg)}
               + {18'd0, item_reg.day} - 25'd1;
        sprod  = $signed(days_reg) * $signed(18'sd86400);
        secs_w = sprod[38:0] + 39'(19'(item_reg.hour) * 19'd3600)
               + 39'(13'(item_reg.minute) * 13'd60) + {32'd0, item_reg.second};
        ok_w   = item_reg.ok && (secs_reg != '1);
    end

    always_ff @(posedge clk)
    begin
        if (rec_take)
        begin
            item_reg <= rec_data;
        end
        if (state_reg == BK_NORM)
        begin
            y_reg    <= y_norm;
            midx_reg <= midx_norm;
        end
        if (state_reg == BK_DIV)
        begin
            p_reg    <= p_w;
            q4_reg   <= p_w[13:2];
            q25_reg  <= prod_p[23:16];
            leap_reg <= leap_w;
        end
        if (state_reg == BK_DAYS)
        begin
            days_reg <= days_w;
        end
        if (state_reg == BK_SECS)
        begin
            secs_reg <= secs_w;
        end
        if (state_reg == BK_FIN)
        begin
            time_valid_reg <= ok_w;
            epoch_reg      <= ok_w ? secs_reg : 39'd0;
            ns_reg         <= ok_w ? item_reg.frac : 30'd0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_pop)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            BK_IDLE:
            begin
                if (rec_take)
                begin
                    state_next = BK_NORM;
                end
            end
            BK_NORM: state_next = BK_DIV;
            BK_DIV:  state_next = BK_DAYS;
            BK_DAYS: state_next = BK_SECS;
            BK_SECS: state_next = BK_FIN;
            BK_FIN:
            begin
                state_next     = BK_IDLE;
                out_valid_next = 1'b1;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
        rec_take |=> (state_reg == BK_NORM))
        else $error("taken record did not start conversion");
    a_fin_output_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_FIN) |-> !out_valid_reg)
        else $error("conversion finished over an unread result");
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !time_valid_reg) |-> (epoch_reg == 39'd0 && ns_reg == 30'd0))
        else $error("invalid result carries nonzero fields");
    a_fin_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_FIN) |=> out_valid_reg)
        else $error("finished conversion did not present a result");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/iso8601_timestamp_parser_unit.sv @@
// Top level of the ISO 8601 UTC timestamp parser.
// Depends on itsp_pkg, itsp_front, itsp_queue and itsp_back.
//
// Usage: characters of a timestamp enter through a queue-style port; an
// item is transferred when push is high and full is low. An item with
// end_of_string set closes the string and yields exactly one result; all
// other items yield none. Results leave through a queue-style port: while
// empty is low the result ports hold the oldest result, which is
// transferred when pop is high.
// The front end takes one character every cycle while full is low. A
// closing item is written to a two-entry record queue; the converter then
// steps a record through take, month normalize, calendar divide, day sum,
// seconds multiply and finish. The converter takes its next record only
// after the previous result is popped, so it does not start a new record
// before the last one is through and its result is read; full rises only
// while the record queue is full.
// When the receiver stalls, the result waits in the output register, the
// converter holds its next record, and the queue fills before full rises.
// The whitespace_ends register is written through cfg_valid/cfg_ready
// (always ready); the user must write it only while the block is idle, as the
// block itself does not enforce this. Reset clears the register, the parse state, the queue and the output.
`default_nettype none
module iso8601_timestamp_parser_unit
    import itsp_pkg::*;
#(
    parameter int FRACTION_DIGITS = 9
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  char_code,
    input  wire logic        end_of_string,
    output logic             empty,
    input  wire logic        pop,
    output logic             time_valid,
    output logic signed [38:0] epoch_seconds,
    output logic [29:0]      nanoseconds,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data
);

    logic  ws_ends_reg;
    logic  accept;
    logic  rec_push;
    item_t rec_in;
    item_t rec_out;
    logic  q_full;
    logic  q_avail;
    logic  rec_take;
    logic  out_valid;
    logic [38:0] epoch_raw;

    assign cfg_ready = 1'b1;
    assign accept    = push && !q_full;
    assign full      = q_full;
    assign empty     = !out_valid;
    assign epoch_seconds = $signed(epoch_raw);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_ends_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            ws_ends_reg <= cfg_data;
        end
    end

    itsp_front #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .char_code     (char_code),
        .end_of_string (end_of_string),
        .ws_ends       (ws_ends_reg),
        .rec_push      (rec_push),
        .rec_data      (rec_in)
    );

    itsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (rec_push),
        .wr_data   (rec_in),
        .full      (q_full),
        .rd_en     (rec_take),
        .not_empty (q_avail),
        .rd_data   (rec_out)
    );

    itsp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec_avail     (q_avail),
        .rec_data      (rec_out),
        .rec_take      (rec_take),
        .out_valid     (out_valid),
        .out_pop       (pop),
        .time_valid    (time_valid),
        .epoch_seconds (epoch_raw),
        .nanoseconds   (nanoseconds)
    );

endmodule
`default_nettype wire

@@ tb/sv/tb_iso8601_timestamp_parser_unit.sv @@
// Self-checking testbench for iso8601_timestamp_parser_unit: a scoreboard class
// predicts each result from the transferred characters and checks the outputs.
// Depends on itsp_pkg and the RTL of the parser.
`timescale 1ns / 100ps
`default_nettype none

import itsp_pkg::*;

typedef struct {
    bit          ok;
    logic [38:0] secs;
    logic [29:0] nsec;
} stamp_t;

// Tracks the parse state of the string in flight and keeps the expected
// timestamps in transfer order.
class timestamp_scoreboard;
    bit          ws_ends;
    phase_t      phase;
    int unsigned ndig;
    int unsigned yr, mo, dy, hr, mi, se, frac;
    bit          zone_seen, failed, finished;
    stamp_t      stamps_due[$];
    int          errors;

    function new();
        ws_ends = 0;
        errors = 0;
        restart();
    endfunction

    function void restart();
        phase = PH_YEAR;
        ndig = 0;
        yr = 0; mo = 0; dy = 1; hr = 0; mi = 0; se = 0; frac = 0;
        zone_seen = 0; failed = 0; finished = 0;
    endfunction

    function int pending();
        return stamps_due.size();
    endfunction

    function int unsigned add_digit(int unsigned f, int unsigned need, int unsigned d);
        ndig++;
        if (ndig >= need)
        begin
            ndig = 0;
            phase = phase_t'(phase + 1);
        end
        return f * 10 + d;
    endfunction

    function longint days_until(longint y);
        longint p;
        p = y - 1;
        return 365 * p + p / 400 - p / 100 + p / 4;
    endfunction

    // Linear normalization of out-of-range fields, the way timegm works.
    function longint to_seconds();
        longint y, m, back, days;
        int     mlen[12];
        bit     leap;
        mlen = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        y = yr;
        m = (phase >= PH_AFTER_MON) ? longint'(mo) - 1 : 0;
        if (m > 11)
        begin
            y += m / 12;
            m = m % 12;
        end
        else if (m < 0)
        begin
            back = (-m + 11) / 12;
            y -= back;
            m += 12 * back;
        end
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        days = days_until(y) - days_until(1970) + dy - 1;
        for (int i = 0; i < m; i++)
        begin
            days += mlen[i];
        end
        if (leap && m >= 2)
        begin
            days += 1;
        end
        return 86400 * days + 3600 * longint'(hr) + 60 * longint'(mi) + longint'(se);
    endfunction

    function void take_char(logic [7:0] ch);
        bit          dig, blank;
        int unsigned d;
        int unsigned weight;
        dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
        d = dig ? int'(ch - CH_ZERO) : 0;
        blank = ws_ends && (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR));
        if (zone_seen)
        begin
            if (blank) finished = 1; else failed = 1;
            return;
        end
        case (phase)
            PH_YEAR:
            begin
                if (!dig) failed = 1;
                else
                begin
                    yr = add_digit(yr, 4, d);
                    if (phase == PH_AFTER_YEAR && yr < 1970) failed = 1;
                end
            end
            PH_MON:  if (!dig) failed = 1; else mo = add_digit(mo, 2, d);
            PH_DAY:
            begin
                if (!dig) failed = 1;
                else
                begin
                    if (ndig == 0) dy = 0;
                    dy = add_digit(dy, 2, d);
                end
            end
            PH_HOUR: if (!dig) failed = 1; else hr = add_digit(hr, 2, d);
            PH_MIN:  if (!dig) failed = 1; else mi = add_digit(mi, 2, d);
            PH_SEC:  if (!dig) failed = 1; else se = add_digit(se, 2, d);
            PH_AFTER_YEAR, PH_AFTER_MON:
            begin
                if (blank) finished = 1;
                else if (ch == CH_DASH) phase = phase_t'(phase + 1);
                else failed = 1;
            end
            PH_AFTER_DAY:
            begin
                if (blank) finished = 1;
                else if (ch == CH_T) phase = PH_HOUR;
                else failed = 1;
            end
            PH_AFTER_HOUR, PH_AFTER_MIN:
            begin
                if (ch == CH_Z) zone_seen = 1;
                else if (ch == CH_COLON) phase = phase_t'(phase + 1);
                else failed = 1;
            end
            PH_AFTER_SEC:
            begin
                if (ch == CH_Z) zone_seen = 1;
                else if (ch == CH_DOT)
                begin
                    phase = PH_FRAC;
                    ndig = 0;
                end
                else failed = 1;
            end
            PH_FRAC:
            begin
                if (dig && ndig < 9)
                begin
                    weight = 1;
                    for (int i = ndig; i < 8; i++) weight *= 10;
                    frac += d * weight;
                    ndig++;
                end
                else if (ch == CH_Z && ndig >= 1) zone_seen = 1;
                else failed = 1;
            end
            default: failed = 1;
        endcase
    endfunction

    // Called for every transferred input item.
    function void note_input(logic [7:0] ch, logic eos);
        stamp_t s;
        longint t;
        if (!eos)
        begin
            if (!failed && !finished) take_char(ch);
            return;
        end
        s.ok = !failed && (finished || zone_seen || phase == PH_AFTER_YEAR ||
                           phase == PH_AFTER_MON || phase == PH_AFTER_DAY);
        t = 0;
        if (s.ok)
        begin
            t = to_seconds();
            if (t == -1) s.ok = 0;
        end
        s.secs = s.ok ? t[38:0] : '0;
        s.nsec = s.ok ? frac[29:0] : '0;
        stamps_due.push_back(s);
        restart();
    endfunction

    // Called for every transferred result.
    function void check_result(logic ok, logic [38:0] secs, logic [29:0] nsec);
        stamp_t s;
        if (stamps_due.size() == 0)
        begin
            $display("%0t: unexpected result valid=%0b secs=%0d ns=%0d",
                     $time, ok, $signed(secs), nsec);
            errors++;
            return;
        end
        s = stamps_due.pop_front();
        if (ok !== s.ok)
        begin
            $display("%0t: time_valid expected %0b actual %0b", $time, s.ok, ok);
            errors++;
        end
        if (secs !== s.secs)
        begin
            $display("%0t: epoch_seconds expected %0d actual %0d", $time,
                     $signed(s.secs), $signed(secs));
            errors++;
        end
        if (nsec !== s.nsec)
        begin
            $display("%0t: nanoseconds expected %0d actual %0d", $time, s.nsec, nsec);
            errors++;
        end
    endfunction
endclass

module tb_iso8601_timestamp_parser_unit;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [7:0]         char_code;
    logic               end_of_string;
    logic               empty;
    logic               pop;
    logic               time_valid;
    logic signed [38:0] epoch_seconds;
    logic [29:0]        nanoseconds;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_data;

    timestamp_scoreboard sb;
    byte unsigned        text[$];
    int                  items_sent;
    int                  results_seen;

    iso8601_timestamp_parser_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .char_code     (char_code),
        .end_of_string (end_of_string),
        .empty         (empty),
        .pop           (pop),
        .time_valid    (time_valid),
        .epoch_seconds (epoch_seconds),
        .nanoseconds   (nanoseconds),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial clk = 0;
    always #5 clk = ~clk;

    // Gap lengths: mostly none, sometimes short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return 0;
        if (r < 97) return $urandom_range(1, 3);
        return $urandom_range(15, 40);
    endfunction

    // Offers one item and returns once it has been transferred. The push
    // from the previous transfer is either replaced or lowered in this step.
    task automatic put_item(logic [7:0] ch, logic eos);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        char_code <= ch;
        end_of_string <= eos;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_input(ch, eos);
        items_sent++;
    endtask

    // Sends the characters in text, then the closing item with a random byte.
    task automatic send_text();
        foreach (text[i]) put_item(text[i], 1'b0);
        put_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_string(string s);
        text = {};
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
        send_text();
    endtask

    // The sender stops, every expected result drains, the converter settles,
    // and only then is the register written.
    task automatic write_whitespace_ends(bit v);
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.ws_ends = v;
    endtask

    function automatic byte unsigned pick_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'h20 : 8'(9 + r);
    endfunction

    function automatic void add_number(int unsigned v, int unsigned n);
        int unsigned p;
        p = 1;
        for (int i = 1; i < n; i++) p *= 10;
        for (int i = 0; i < n; i++)
        begin
            text.push_back(8'(CH_ZERO + (v / p) % 10));
            p /= 10;
        end
    endfunction

    // Field value: usually in range, sometimes anything two digits allow.
    function automatic int unsigned pick_field(int unsigned lo, int unsigned hi);
        return ($urandom_range(0, 9) < 8) ? $urandom_range(lo, hi) : $urandom_range(0, 99);
    endfunction

    // Builds a mostly well-formed timestamp with random content; a share of
    // them are random bytes or get trailing whitespace, a broken character, a cut or an inserted blank.
    task automatic build_random();
        int form, k, pos, r;
        text = {};
        if ($urandom_range(0, 19) == 0)
        begin
            k = $urandom_range(0, 6);
            repeat (k) text.push_back(8'($urandom_range(0, 255)));
            return;
        end
        form = $urandom_range(0, 6);
        add_number(($urandom_range(0, 99) < 88) ? $urandom_range(1970, 9999)
                                                : $urandom_range(0, 1969), 4);
        if (form >= 1)
        begin
            text.push_back(CH_DASH);
            add_number(pick_field(1, 12), 2);
        end
        if (form >= 2)
        begin
            text.push_back(CH_DASH);
            add_number(pick_field(1, 31), 2);
        end
        if (form >= 3)
        begin
            text.push_back(CH_T);
            add_number(pick_field(0, 23), 2);
        end
        if (form >= 4)
        begin
            text.push_back(CH_COLON);
            add_number(pick_field(0, 59), 2);
        end
        if (form >= 5)
        begin
            text.push_back(CH_COLON);
            add_number(pick_field(0, 59), 2);
        end
        if (form == 6)
        begin
            text.push_back(CH_DOT);
            k = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1) * 10 : $urandom_range(1, 9);
            repeat (k) text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end
        if (form >= 3) text.push_back(CH_Z);
        if ($urandom_range(0, 3) == 0)
        begin
            text.push_back(pick_blank());
            k = $urandom_range(0, 3);
            repeat (k) text.push_back(8'($urandom_range(0, 255)));
        end
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            pos = $urandom_range(0, text.size() - 1);
            text[pos] = 8'($urandom_range(0, 255));
        end
        else if (r < 12)
        begin
            k = $urandom_range(0, text.size());
            while (text.size() > k) void'(text.pop_back());
        end
        else if (r < 15)
        begin
            pos = $urandom_range(0, text.size());
            text.insert(pos, pick_blank());
        end
    endtask

    // Extremes, every separator, and the special cases of the grammar.
    task automatic run_directed();
        send_string("");
        send_string("1970");
        send_string("1969");
        send_string("0000");
        send_string("2000-00");
        send_string("9999-99-99T99:99:99.999999999Z");
        send_string("1970-01-00T23:59:59Z");
        send_string("1970-01-00T23:59:59.5Z");
        send_string("2024-02-29T12:34:56.1Z");
        send_string("2024-02-29T12:34:56.1234567890Z");
        send_string("2024-05-05T05:05Z");
        send_string("2024-01-01T10Z\t");
        send_string("2024-01-01T10Z x");
        send_string("2024-01-01T10 ");
        send_string("2024 x");
        send_string("2024-06-15\nrest");
        send_string("2024-");
        send_string("2024-01-01T12:00:00.Z");
        send_string("12a4");
        text = {8'h32, 8'h30, 8'hFF};
        send_text();
    endtask

    // Random strings until this phase has sent its share of items.
    task automatic run_random(int quota);
        int goal;
        goal = items_sent + quota;
        while (items_sent < goal)
        begin
            build_random();
            send_text();
        end
    endtask

    // Result side: checks each transfer, pops with random gaps, and once
    // holds off for a long stretch so that the input side fills and stalls.
    initial
    begin
        int  stall;
        bit  long_hold_done;
        int  r;
        stall = 0;
        long_hold_done = 0;
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                sb.check_result(time_valid, epoch_seconds, nanoseconds);
                results_seen++;
            end
            if (!long_hold_done && results_seen >= 60)
            begin
                long_hold_done = 1;
                stall = 400;
            end
            if (stall > 0)
            begin
                stall--;
                pop <= 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70) pop <= 1'b1;
                else
                begin
                    pop <= 1'b0;
                    stall = (r < 97) ? $urandom_range(0, 3) : $urandom_range(20, 60);
                end
            end
        end
    end

    // Main sequence: directed strings under both register settings, then
    // random phases that alternate the setting.
    initial
    begin
        sb = new();
        items_sent = 0;
        results_seen = 0;
        rst_n = 1'b0;
        push = 1'b0;
        char_code = '0;
        end_of_string = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        write_whitespace_ends(1'b1);
        run_directed();
        write_whitespace_ends(1'b0);
        run_random(300);
        write_whitespace_ends(1'b1);
        run_random(350);
        write_whitespace_ends(1'b0);
        run_random(270);
        write_whitespace_ends(1'b1);
        run_random(270);
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(20_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/itsp_pkg.sv
hw/rtl/itsp_front.sv
hw/rtl/itsp_queue.sv
hw/rtl/itsp_back.sv
hw/rtl/iso8601_timestamp_parser_unit.sv
tb/sv/tb_iso8601_timestamp_parser_unit.sv
